@@ rtl/rgp2c_pkg.sv @@
package rgp2c_pkg;

  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned ATAN_COUNT  = 30;
  localparam int unsigned GUARD_BITS  = 14;

  localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;
  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [31:0] KINV_Q30    = 32'sd652032874;

  // floor(2^49 / 2pi in Q28) = floor(2^21 / 2pi), used to estimate the turn count
  localparam logic signed [19:0] TURN_RECIP =
    20'((64'sd1 <<< 49) / 64'(TWO_PI_Q28));

  localparam logic signed [31:0] SENT_NEG_ONE = -32'sd65536;
  localparam logic signed [31:0] SENT_POS_999 = 32'sd65470464;
  localparam logic signed [31:0] SENT_NEG_999 = -32'sd65470464;

  typedef enum logic [7:0] {
    CFG_RANGE_LOWER = 8'd0,
    CFG_RANGE_UPPER = 8'd1,
    CFG_START_ANGLE = 8'd2,
    CFG_ANGLE_STEP  = 8'd3
  } cfg_reg_e;

  function automatic logic signed [31:0] atan_q28(input int unsigned k);
    case (k)
      0:  return 32'sd210828714;
      1:  return 32'sd124459457;
      2:  return 32'sd65760959;
      3:  return 32'sd33381290;
      4:  return 32'sd16755422;
      5:  return 32'sd8385879;
      6:  return 32'sd4193963;
      7:  return 32'sd2097109;
      8:  return 32'sd1048571;
      9:  return 32'sd524287;
      10: return 32'sd262144;
      11: return 32'sd131072;
      12: return 32'sd65536;
      13: return 32'sd32768;
      14: return 32'sd16384;
      15: return 32'sd8192;
      16: return 32'sd4096;
      17: return 32'sd2048;
      18: return 32'sd1024;
      19: return 32'sd512;
      20: return 32'sd256;
      21: return 32'sd128;
      22: return 32'sd64;
      23: return 32'sd32;
      24: return 32'sd16;
      25: return 32'sd8;
      26: return 32'sd4;
      27: return 32'sd2;
      28: return 32'sd1;
      29: return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  // round half up out of the guard bits, apply the fold sign, saturate
  function automatic logic signed [31:0] round_sat(input logic signed [47:0] v,
                                                   input logic neg);
    logic signed [47:0] t;
    logic signed [34:0] r;
    t = v + 48'sd8192;
    r = 35'(t >>> GUARD_BITS);
    if (neg) begin
      r = -r;
    end
    if (r > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (r < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

endpackage

@@ rtl/range_gate_polar_to_cartesian.sv @@
// throughput: one sample per cycle while the skid word is empty, set by the CORDIC
// pipeline with one rotation per stage
// a full output plus skid word stalls the whole pipeline until the output is taken
// rejected samples leave a bubble and give no output word
// reset (async, active low) empties the pipeline and loads the register defaults
module range_gate_polar_to_cartesian
  import rgp2c_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] range_sample_i,
  input  logic        [9:0]  sample_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] x_pos_o,
  output logic signed [31:0] y_pos_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [7:0]  cfg_index_i,
  input  logic        [31:0] cfg_data_i
);

  localparam int unsigned NC = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

  localparam logic signed [33:0] PI_W       = 34'(PI_Q28);
  localparam logic signed [33:0] TWO_PI_W   = 34'(TWO_PI_Q28);
  localparam logic signed [33:0] THREE_PI_W = 34'(PI_Q28) + 34'(TWO_PI_Q28);
  localparam logic signed [33:0] FOUR_PI_W  = 34'(TWO_PI_Q28) + 34'(TWO_PI_Q28);

  // configuration
  logic signed [31:0] lower_q, upper_q, start_q, step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= 32'sd0;
      upper_q <= 32'sh7fffffff;
      start_q <= 32'sd0;
      step_q  <= 32'sd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RANGE_LOWER: lower_q <= cfg_data_i;
        CFG_RANGE_UPPER: upper_q <= cfg_data_i;
        CFG_START_ANGLE: start_q <= cfg_data_i;
        CFG_ANGLE_STEP:  step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance, held while the skid word is occupied
  logic adv;
  logic skid_v_q;

  assign adv        = !skid_v_q;
  assign in_ready_o = adv;

  // range gate
  logic keep;
  always_comb begin
    keep = ({7'd0, sample_index_i} < 17'(MAX_SAMPLES));
    if (range_sample_i == SENT_NEG_ONE || range_sample_i == SENT_POS_999 ||
        range_sample_i == SENT_NEG_999) begin
      keep = 1'b0;
    end
    if (range_sample_i[31] || range_sample_i < lower_q || range_sample_i > upper_q) begin
      keep = 1'b0;
    end
  end

  // stage 1: index product and gain-compensated range
  logic signed [42:0] prod_d, prod_q;
  logic signed [63:0] kx;
  logic               p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, p6_v_q;
  logic signed [47:0] x1_q, x2_q, x3_q, x4_q, x5_q, x6_q;

  assign prod_d = $signed({1'b0, sample_index_i}) * step_q;
  assign kx     = range_sample_i * KINV_Q30;

  // stage 2: absolute angle
  logic signed [42:0] sum_d, sum2_q, sum3_q, sum4_q;
  assign sum_d = start_q + prod_q;

  // stage 3: turn estimate
  logic signed [43:0] sr_d, sr_q;
  assign sr_d = $signed(sum2_q[42:19]) * TURN_RECIP;

  // stage 4: whole turns to remove
  logic signed [45:0] qm_d, qm_q;
  assign qm_d = $signed(sr_q[43:30]) * TWO_PI_Q28;

  // stage 5: remainder in [-2pi, 4pi)
  logic signed [45:0] diff;
  logic signed [33:0] r_q;
  assign diff = sum4_q - qm_q;

  // stage 6: reduce into [-pi, pi)
  logic signed [33:0] a_d;
  logic signed [30:0] a_q;
  always_comb begin
    if (r_q >= THREE_PI_W) begin
      a_d = r_q - FOUR_PI_W;
    end else if (r_q >= PI_W) begin
      a_d = r_q - TWO_PI_W;
    end else if (r_q < -PI_W) begin
      a_d = r_q + TWO_PI_W;
    end else begin
      a_d = r_q;
    end
  end

  // stage 7: fold by pi into [-pi/2, pi/2]
  logic signed [31:0] a_ext, z_d;
  logic               neg_d;
  assign a_ext = 32'(a_q);
  always_comb begin
    if (a_ext > HALF_PI_Q28) begin
      z_d   = a_ext - PI_Q28;
      neg_d = 1'b1;
    end else if (a_ext < -HALF_PI_Q28) begin
      z_d   = a_ext + PI_Q28;
      neg_d = 1'b1;
    end else begin
      z_d   = a_ext;
      neg_d = 1'b0;
    end
  end

  logic signed [47:0] cx_q [NC+1];
  logic signed [47:0] cy_q [NC+1];
  logic signed [31:0] cz_q [NC+1];
  logic               cn_q [NC+1];
  logic               cv_q [NC+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      p5_v_q  <= 1'b0;
      p6_v_q  <= 1'b0;
      cv_q[0] <= 1'b0;
    end else if (adv) begin
      p1_v_q  <= in_valid_i & keep;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      p5_v_q  <= p4_v_q;
      p6_v_q  <= p5_v_q;
      cv_q[0] <= p6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q  <= prod_d;
      x1_q    <= kx[63:16];
      sum2_q  <= sum_d;
      x2_q    <= x1_q;
      sr_q    <= sr_d;
      sum3_q  <= sum2_q;
      x3_q    <= x2_q;
      qm_q    <= qm_d;
      sum4_q  <= sum3_q;
      x4_q    <= x3_q;
      r_q     <= diff[33:0];
      x5_q    <= x4_q;
      a_q     <= a_d[30:0];
      x6_q    <= x5_q;
      cx_q[0] <= x6_q;
      cy_q[0] <= 48'sd0;
      cz_q[0] <= z_d;
      cn_q[0] <= neg_d;
    end
  end

  // cordic rotation, one micro-rotation per stage
  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic signed [47:0] dx, dy;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (adv) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cn_q[i+1] <= cn_q[i];
        if (!cz_q[i][31]) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - atan_q28(i);
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + atan_q28(i);
        end
      end
    end
  end

  // output word and skid word
  logic               fin_v;
  logic signed [31:0] fin_x, fin_y;
  logic               out_v_q;
  logic signed [31:0] out_x_q, out_y_q, skid_x_q, skid_y_q;

  assign fin_v = cv_q[NC] & adv;
  assign fin_x = round_sat(cx_q[NC], cn_q[NC]);
  assign fin_y = round_sat(cy_q[NC], cn_q[NC]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q  <= skid_v_q | fin_v;
      skid_v_q <= 1'b0;
    end else if (fin_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_x_q <= skid_x_q;
        out_y_q <= skid_y_q;
      end else begin
        out_x_q <= fin_x;
        out_y_q <= fin_y;
      end
    end else if (fin_v) begin
      skid_x_q <= fin_x;
      skid_y_q <= fin_y;
    end
  end

  assign out_valid_o = out_v_q;
  assign x_pos_o     = out_x_q;
  assign y_pos_o     = out_y_q;

`ifndef SYNTH
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word held without an output word");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i && cv_q[NC]))
    else $error("skid word filled without a stalled output");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(cv_q[NC]) && $stable(cv_q[0]) && $stable(p1_v_q))
    else $error("pipeline moved while stalled");
`endif

endmodule

@@ verif/tb.sv @@
module tb;
  import rgp2c_pkg::*;

  localparam int STAGES      = 24;
  localparam int PIPE_DEPTH  = 8 + STAGES + 8;
  localparam int CYCLE_LIMIT = 400000;

  localparam longint TWO_PI_RAD  = 1686629713;
  localparam longint PI_RAD      = 843314857;
  localparam longint HALF_PI_RAD = 421657428;
  localparam longint GAIN_COMP   = 652032874;
  localparam longint NEG_ONE_M   = -65536;
  localparam longint POS_999_M   = 65470464;
  localparam longint NEG_999_M   = -65470464;

  localparam longint ATAN_TAB [30] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 1
  };

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] range_sample = '0;
  logic        [9:0]  sample_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [7:0]  cfg_index = '0;
  logic        [31:0] cfg_data = '0;

  longint range_min_q;
  longint range_max_q;
  longint start_ang_q;
  longint step_ang_q;

  point_t expected_points[$];
  point_t got_point;
  int     mismatches = 0;
  int     cycle_count = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     hold_cycles = 0;

  range_gate_polar_to_cartesian #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .range_sample_i(range_sample),
    .sample_index_i(sample_index),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .x_pos_o       (x_pos),
    .y_pos_o       (y_pos),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic signed [31:0] round_out(input longint v, input bit flip);
    longint r;
    r = (v + 8192) >>> 14;
    if (flip) begin
      r = -r;
    end
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end
    return r[31:0];
  endfunction

  function automatic bit rotate_sample(input logic signed [31:0] rng, input logic [9:0] idx,
                                       output point_t pt);
    longint r;
    longint ang;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    r = rng;
    flip = 1'b0;
    pt = '0;
    if (r == NEG_ONE_M || r == POS_999_M || r == NEG_999_M) begin
      return 1'b0;
    end
    if (r < 0 || r < range_min_q || r > range_max_q) begin
      return 1'b0;
    end
    ang = (start_ang_q + longint'(idx) * step_ang_q) % TWO_PI_RAD;
    if (ang >= PI_RAD) begin
      ang -= TWO_PI_RAD;
    end
    if (ang < -PI_RAD) begin
      ang += TWO_PI_RAD;
    end
    // fold into the right half plane, sign restored at the end
    if (ang > HALF_PI_RAD) begin
      ang -= PI_RAD;
      flip = 1'b1;
    end else if (ang < -HALF_PI_RAD) begin
      ang += PI_RAD;
      flip = 1'b1;
    end
    x = (r * GAIN_COMP) >>> 16;
    y = 0;
    for (int i = 0; i < STAGES && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ang >= 0) begin
        x -= dx;
        y += dy;
        ang -= ATAN_TAB[i];
      end else begin
        x += dx;
        y -= dy;
        ang += ATAN_TAB[i];
      end
    end
    pt.x = round_out(x, flip);
    pt.y = round_out(y, flip);
    return 1'b1;
  endfunction

  task automatic send_sample(input logic signed [31:0] rng, input logic [9:0] idx);
    point_t pt;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    range_sample <= rng;
    sample_index <= idx;
    do @(posedge clk); while (!in_ready);
    if (rotate_sample(rng, idx, pt)) begin
      expected_points.push_back(pt);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RANGE_LOWER: range_min_q = $signed(data);
      CFG_RANGE_UPPER: range_max_q = $signed(data);
      CFG_START_ANGLE: start_ang_q = $signed(data);
      CFG_ANGLE_STEP:  step_ang_q  = $signed(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_window(input logic [31:0] lo, input logic [31:0] hi);
    write_reg(CFG_RANGE_LOWER, lo);
    write_reg(CFG_RANGE_UPPER, hi);
  endtask

  task automatic write_angles(input logic [31:0] start, input logic [31:0] step);
    write_reg(CFG_START_ANGLE, start);
    write_reg(CFG_ANGLE_STEP, step);
  endtask

  task automatic test_gate_defaults();
    send_sample(32'sd0, 10'd0);
    send_sample(32'sd1, 10'd1023);
    send_sample(32'sh7fffffff, 10'd5);
    send_sample(32'sh80000000, 10'd0);
    send_sample(-32'sd5, 10'd0);
    send_sample(NEG_ONE_M[31:0], 10'd0);
    send_sample(POS_999_M[31:0], 10'd0);
    send_sample(NEG_999_M[31:0], 10'd0);
    send_sample(POS_999_M[31:0] + 32'sd1, 10'h2aa);
    wait_idle();
  endtask

  task automatic test_range_window();
    write_window(32'sd10 <<< 16, 32'sd20 <<< 16);
    send_sample((32'sd10 <<< 16) - 32'sd1, 10'd0);
    send_sample(32'sd10 <<< 16, 10'd0);
    send_sample(32'sd20 <<< 16, 10'd0);
    send_sample((32'sd20 <<< 16) + 32'sd1, 10'd0);
    wait_idle();
    // empty window at the extremes
    write_window(32'h7fffffff, 32'h80000000);
    send_sample(32'sh7fffffff, 10'd0);
    send_sample(32'sd0, 10'd0);
    wait_idle();
    write_window(32'h80000000, 32'h7fffffff);
  endtask

  task automatic test_quadrants();
    write_angles(32'd0, HALF_PI_RAD[31:0] >> 1);
    for (int i = 0; i < 8; i++) begin
      send_sample(32'sd1000 <<< 16, 10'(i));
    end
    wait_idle();
    write_angles(PI_RAD[31:0], 32'd0);
    send_sample(32'sd3 <<< 16, 10'd0);
    wait_idle();
    write_angles(32'h7fffffff, 32'h80000000);
    send_sample(32'sh7fffffff, 10'd1023);
    send_sample(32'sd12345678, 10'd512);
    wait_idle();
  endtask

  function automatic logic signed [31:0] pick_range();
    longint lo;
    longint v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(2))
          0: v = NEG_ONE_M;
          1: v = POS_999_M;
          default: v = NEG_999_M;
        endcase
      end
      1: v = $signed($urandom);
      2: begin
        v = $urandom_range(1) ? range_min_q : range_max_q;
        v += longint'($urandom_range(2)) - 1;
      end
      default: begin
        lo = (range_min_q < 0) ? 0 : range_min_q;
        if (lo > range_max_q) begin
          v = $signed($urandom);
        end else begin
          v = lo + longint'($urandom) % (range_max_q - lo + 1);
        end
      end
    endcase
    return v[31:0];
  endfunction

  task automatic test_random_phase(input int idle, input int stall, input int count);
    write_window($urandom_range(3) == 0 ? 32'h80000000 : $urandom_range(50) << 16,
                 $urandom_range(3) == 0 ? 32'h7fffffff : $urandom_range(60, 30000) << 16);
    write_angles($urandom, $urandom_range(1) ? $urandom : $urandom >> $urandom_range(8, 24));
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) begin
      send_sample(pick_range(), 10'($urandom));
    end
    wait_idle();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_window(32'd0, 32'h7fffffff);
    write_angles($urandom, $urandom);
    hold_cycles = 400;
    repeat (150) begin
      send_sample($urandom_range(32'h7fffffff), 10'($urandom));
    end
    wait_idle();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word x_pos %0d y_pos %0d", $time, x_pos, y_pos);
      end else begin
        got_point = expected_points.pop_front();
        if (got_point.x !== x_pos) begin
          mismatches++;
          $display("%0t: x_pos expected %0d got %0d", $time, got_point.x, x_pos);
        end
        if (got_point.y !== y_pos) begin
          mismatches++;
          $display("%0t: y_pos expected %0d got %0d", $time, got_point.y, y_pos);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** range_gate_polar_to_cartesian: FAILED **");
      $finish;
    end
  end

  initial begin
    range_min_q = 0;
    range_max_q = 64'sd2147483647;
    start_ang_q = 0;
    step_ang_q  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_gate_defaults();
    test_range_window();
    test_quadrants();
    test_random_phase(0, 0, 450);
    test_random_phase(80, 0, 450);
    test_random_phase(0, 80, 450);
    test_random_phase(11, 11, 450);
    test_backpressure();
    if (mismatches == 0) begin
      $display("** range_gate_polar_to_cartesian: PASSED **");
    end else begin
      $display("** range_gate_polar_to_cartesian: FAILED **");
    end
    $finish;
  end

endmodule
